// ===== design/ctfu_pkg.sv =====
// shared types and constants of the constrained-transport face field update unit
// word format, request and result structs, register indexes and status codes
// depends on nothing
package ctfu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // blended field and edge curl, before scaling
    localparam int GW = 2 * WORD_BITS + 3;
    // numerator over the area, and the rounded form of its magnitude
    localparam int NW = 3 * WORD_BITS + 5;
    localparam int NX = NW + 2;
    // doubled scaled area, the divisor
    localparam int DW2 = WORD_BITS + FRAC_BITS + 1;

    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_CURRENT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_OLD     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SCALE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULTI_DIM    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THREE_DIM    = 3'd4;

    localparam logic [1:0] ACT_X1   = 2'd0;
    localparam logic [1:0] ACT_X2   = 2'd1;
    localparam logic [1:0] ACT_X3   = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_AREA = 2'd2;

    localparam logic [WORD_BITS-1:0] GAIN_ONE = WORD_BITS'(1) << FRAC_BITS;
    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_CALC = 2'd0,
        KIND_PASS = 2'd1,
        KIND_ZERO = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]                  action;
        logic signed [WORD_BITS-1:0] field_now;
        logic signed [WORD_BITS-1:0] field_old;
        logic [WORD_BITS-1:0]        face_area;
        logic [WORD_BITS-1:0]        len_a_lo;
        logic [WORD_BITS-1:0]        len_a_hi;
        logic signed [WORD_BITS-1:0] emf_a_lo;
        logic signed [WORD_BITS-1:0] emf_a_hi;
        logic [WORD_BITS-1:0]        len_b_lo;
        logic [WORD_BITS-1:0]        len_b_hi;
        logic signed [WORD_BITS-1:0] emf_b_lo;
        logic signed [WORD_BITS-1:0] emf_b_hi;
    } t_req;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] field_new;
        logic [1:0]                  status;
    } t_rsp;

    // travels alongside the data through both pipelines
    typedef struct packed {
        t_kind                kind;
        logic [WORD_BITS-1:0] pass_val;
        logic [WORD_BITS-1:0] area;
    } t_tag;

endpackage

// ===== design/ctfu_mac.sv =====
// multiply-accumulate pipeline: builds the signed numerator over the face area
// five register stages, 32x32-class multipliers only; uses ctfu_pkg
module ctfu_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  ctfu_pkg::t_req                        i_req,
    input  logic signed [ctfu_pkg::WORD_BITS-1:0] i_gain_current,
    input  logic signed [ctfu_pkg::WORD_BITS-1:0] i_gain_old,
    input  logic signed [ctfu_pkg::WORD_BITS-1:0] i_step_scale,
    input  logic                                  i_multi_dim,
    input  logic                                  i_three_dim,
    output logic                                  o_valid,
    output ctfu_pkg::t_tag                        o_tag,
    output logic signed [ctfu_pkg::NW-1:0]        o_num
);
    import ctfu_pkg::*;

    localparam int W = WORD_BITS;

    logic [5:1] r_vld;

    t_tag                 r1_tag;
    logic signed [2*W-1:0] r1_pg_cur, r1_pg_old;
    logic signed [2*W:0]   r1_pa_hi, r1_pa_lo, r1_pb_hi, r1_pb_lo;
    logic                 r1_sa_neg, r1_use_b;

    t_tag                 r2_tag;
    logic signed [GW-1:0] r2_g, r2_dt;

    t_tag                   r3_tag;
    logic [2*W-1:0]         r3_gl;
    logic signed [2*W+3:0]  r3_gh;
    logic signed [2*W:0]    r3_dl;
    logic signed [2*W+2:0]  r3_dh;

    t_tag                 r4_tag;
    logic signed [NW-1:0] r4_ga, r4_ds;

    t_tag                 r5_tag;
    logic signed [NW-1:0] r5_num;

    t_kind                n_kind;
    logic signed [GW-1:0] n_da, n_db, n_db_use;

    always_comb begin
        if (i_req.action == ACT_NONE || (i_req.action == ACT_X1 && !i_multi_dim)) begin
            n_kind = KIND_PASS;
        end else if (i_req.face_area == '0) begin
            n_kind = KIND_ZERO;
        end else begin
            n_kind = KIND_CALC;
        end
    end

    always_comb begin
        n_da = GW'(r1_pa_hi) - GW'(r1_pa_lo);
        n_db = GW'(r1_pb_hi) - GW'(r1_pb_lo);
        n_db_use = r1_use_b ? n_db : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: edge and gain products
        r1_tag.kind     <= n_kind;
        r1_tag.pass_val <= i_req.field_now;
        r1_tag.area     <= i_req.face_area;
        r1_pg_cur <= i_gain_current * i_req.field_now;
        r1_pg_old <= i_gain_old * i_req.field_old;
        r1_pa_hi  <= $signed({1'b0, i_req.len_a_hi}) * i_req.emf_a_hi;
        r1_pa_lo  <= $signed({1'b0, i_req.len_a_lo}) * i_req.emf_a_lo;
        r1_pb_hi  <= $signed({1'b0, i_req.len_b_hi}) * i_req.emf_b_hi;
        r1_pb_lo  <= $signed({1'b0, i_req.len_b_lo}) * i_req.emf_b_lo;
        r1_sa_neg <= (i_req.action != ACT_X2);
        r1_use_b  <= (i_req.action == ACT_X3) ? i_multi_dim : i_three_dim;

        // stage 2: blend and signed curl, b term sign is the opposite of a
        r2_tag <= r1_tag;
        r2_g   <= GW'(r1_pg_cur) + GW'(r1_pg_old);
        r2_dt  <= r1_sa_neg ? (n_db_use - n_da) : (n_da - n_db_use);

        // stage 3: partial products split at the word boundary
        r3_tag <= r2_tag;
        r3_gl  <= r2_g[W-1:0] * r2_tag.area;
        r3_gh  <= $signed(r2_g[GW-1:W]) * $signed({1'b0, r2_tag.area});
        r3_dl  <= $signed({1'b0, r2_dt[W-1:0]}) * i_step_scale;
        r3_dh  <= $signed(r2_dt[GW-1:W]) * i_step_scale;

        // stage 4: recombine partial products
        r4_tag <= r3_tag;
        r4_ga  <= (NW'(r3_gh) <<< W) + NW'($signed({1'b0, r3_gl}));
        r4_ds  <= (NW'(r3_dh) <<< W) + NW'(r3_dl);

        // stage 5: full numerator
        r5_tag <= r4_tag;
        r5_num <= r4_ga + r4_ds;
    end

    assign o_valid = r_vld[5];
    assign o_tag   = r5_tag;
    assign o_num   = r5_num;

endmodule

// ===== design/ctfu_div.sv =====
// rounding, pipelined restoring divider and saturation of the face update
// one quotient bit per stage plus two set-up stages and an output register; uses ctfu_pkg
module ctfu_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  ctfu_pkg::t_tag                 i_tag,
    input  logic signed [ctfu_pkg::NW-1:0] i_num,
    output logic                           o_done,
    output ctfu_pkg::t_rsp                 o_rsp
);
    import ctfu_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int HW = NX - W;

    // set-up stage: magnitude plus half divisor for round half away from zero
    logic               r_a_vld;
    t_tag               r_a_tag;
    logic               r_a_neg;
    logic [NX-1:0]      r_a_x;
    logic [DW2-1:0]     r_a_d2;
    logic [NW-1:0]      n_mag;

    always_comb begin
        n_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    end

    // divider stages, index 0 is loaded from the set-up stage
    logic           r_vld  [W+1];
    t_tag           r_tag  [W+1];
    logic           r_neg  [W+1];
    logic           r_pre  [W+1];
    logic [DW2-1:0] r_rem  [W+1];
    logic [W-1:0]   r_low  [W+1];
    logic [W-1:0]   r_q    [W+1];
    logic [DW2-1:0] r_d2   [W+1];

    logic [HW-1:0]  n_hi;

    assign n_hi = r_a_x[NX-1:W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_vld[0] <= 1'b0;
        end else begin
            r_a_vld  <= i_valid;
            r_vld[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_tag <= i_tag;
        r_a_neg <= i_num[NW-1];
        r_a_x   <= NX'({n_mag, 1'b0}) + NX'({i_tag.area, {FRAC_BITS{1'b0}}});
        r_a_d2  <= {i_tag.area, {(FRAC_BITS+1){1'b0}}};

        // quotient of a word or more saturates anyway
        r_tag[0] <= r_a_tag;
        r_neg[0] <= r_a_neg;
        r_pre[0] <= (n_hi >= HW'(r_a_d2));
        r_rem[0] <= n_hi[DW2-1:0];
        r_low[0] <= r_a_x[W-1:0];
        r_q[0]   <= '0;
        r_d2[0]  <= r_a_d2;
    end

    for (genvar k = 0; k < W; k++) begin : g_step
        logic [DW2:0] s_t;
        logic         s_ge;

        always_comb begin
            s_t  = {r_rem[k], r_low[k][W-1]};
            s_ge = (s_t >= {1'b0, r_d2[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k+1] <= r_tag[k];
            r_neg[k+1] <= r_neg[k];
            r_pre[k+1] <= r_pre[k];
            r_rem[k+1] <= s_ge ? DW2'(s_t - {1'b0, r_d2[k]}) : s_t[DW2-1:0];
            r_low[k+1] <= r_low[k] << 1;
            r_q[k+1]   <= {r_q[k][W-2:0], s_ge};
            r_d2[k+1]  <= r_d2[k];
        end
    end

    // output register
    logic   r_done;
    t_rsp   r_rsp;
    logic   n_over;
    t_rsp   n_rsp;

    always_comb begin
        // a negative result may reach one past the positive limit
        n_over = r_pre[W] || (r_q[W][W-1] && (!r_neg[W] || r_q[W][W-2:0] != '0));
        case (r_tag[W].kind)
            KIND_PASS: begin
                n_rsp.field_new = r_tag[W].pass_val;
                n_rsp.status    = STAT_OK;
            end
            KIND_ZERO: begin
                n_rsp.field_new = '0;
                n_rsp.status    = STAT_AREA;
            end
            default: begin
                if (n_over) begin
                    n_rsp.field_new = r_neg[W] ? WORD_MIN : WORD_MAX;
                    n_rsp.status    = STAT_SAT;
                end else begin
                    n_rsp.field_new = r_neg[W] ? W'(-r_q[W]) : r_q[W];
                    n_rsp.status    = STAT_OK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== design/ct_face_field_update_unit.sv =====
// face field update unit: from request to the o_done strobe a face passes the ctfu_mac stages,
// the divider set-up stages, one divider stage per quotient bit and the output register; one
// request is taken every clock, as all of these are fully pipelined. o_busy stays low, the receiver
// cannot stall. synchronous active-low reset clears the pipeline valid bits and loads
// the register defaults (gain_current 1.0, gain_old 0, step_scale 0, both dimension flags)
// top level: configuration registers, ctfu_mac and ctfu_div; uses ctfu_pkg
module ct_face_field_update_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  ctfu_pkg::t_req                       i_req,
    output logic                                 o_done,
    output ctfu_pkg::t_rsp                       o_rsp,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ctfu_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [ctfu_pkg::WORD_BITS-1:0]       i_cfg_data
);
    import ctfu_pkg::*;

    logic signed [WORD_BITS-1:0] r_gain_current, r_gain_old, r_step_scale;
    logic                        r_multi_dim, r_three_dim;

    logic                 s_mac_valid;
    t_tag                 s_mac_tag;
    logic signed [NW-1:0] s_mac_num;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_current <= GAIN_ONE;
            r_gain_old     <= '0;
            r_step_scale   <= '0;
            r_multi_dim    <= 1'b1;
            r_three_dim    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GAIN_CURRENT: r_gain_current <= i_cfg_data;
                CFG_GAIN_OLD:     r_gain_old     <= i_cfg_data;
                CFG_STEP_SCALE:   r_step_scale   <= i_cfg_data;
                CFG_MULTI_DIM:    r_multi_dim    <= i_cfg_data[0];
                CFG_THREE_DIM:    r_three_dim    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ctfu_mac u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_start && !o_busy),
        .i_req          (i_req),
        .i_gain_current (r_gain_current),
        .i_gain_old     (r_gain_old),
        .i_step_scale   (r_step_scale),
        .i_multi_dim    (r_multi_dim),
        .i_three_dim    (r_three_dim),
        .o_valid        (s_mac_valid),
        .o_tag          (s_mac_tag),
        .o_num          (s_mac_num)
    );

    ctfu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_mac_valid),
        .i_tag   (s_mac_tag),
        .i_num   (s_mac_num),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == STAT_SAT) |->
        (o_rsp.field_new == WORD_MAX || o_rsp.field_new == WORD_MIN))
        else $error("saturated result is not a limit word");

    a_area_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == STAT_AREA) |-> (o_rsp.field_new == '0))
        else $error("zero area result is not zero");

    a_cfg_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_GAIN_CURRENT) |=>
        (r_gain_current == $past(i_cfg_data)))
        else $error("gain_current write lost");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench of the face field update unit: random and directed face requests under
// varying register settings, checked against an exact wide-integer predictor
// depends on ctfu_pkg and ct_face_field_update_unit
module tb;
    import ctfu_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_start;
    logic                        o_busy;
    t_req                        i_req;
    logic                        o_done;
    t_rsp                        o_rsp;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]     i_cfg_index;
    logic [WORD_BITS-1:0]        i_cfg_data;

    ct_face_field_update_unit i_dut (.*);

    // register copy used for prediction
    logic [WORD_BITS-1:0] gain_cur_r, gain_old_r, step_r;
    logic                 multi_r, three_r;

    t_req pending_faces[$];
    t_rsp expected_fields[$];
    int   errors, faces_sent, fields_seen, sat_seen, area_seen, idle_cycles;
    int   burst_left, gap_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_rsp predict_face(t_req r);
        logic signed [127:0] gc, go, fn, fo, area, stp, da, db, num;
        logic [127:0]        mag, den, quo;
        logic                neg, use_b;
        t_rsp                res;
        if (r.action == ACT_NONE || (r.action == ACT_X1 && !multi_r)) begin
            res.field_new = r.field_now;
            res.status    = STAT_OK;
            return res;
        end
        if (r.face_area == '0) begin
            res.field_new = '0;
            res.status    = STAT_AREA;
            return res;
        end
        gc   = $signed(gain_cur_r);
        go   = $signed(gain_old_r);
        stp  = $signed(step_r);
        fn   = r.field_now;
        fo   = r.field_old;
        area = {96'b0, r.face_area};
        da   = $signed({96'b0, r.len_a_hi}) * $signed(r.emf_a_hi)
             - $signed({96'b0, r.len_a_lo}) * $signed(r.emf_a_lo);
        db   = $signed({96'b0, r.len_b_hi}) * $signed(r.emf_b_hi)
             - $signed({96'b0, r.len_b_lo}) * $signed(r.emf_b_lo);
        use_b = (r.action == ACT_X3) ? multi_r : three_r;
        num = (gc * fn + go * fo) * area;
        if (r.action == ACT_X2) num = num + stp * da;
        else                    num = num - stp * da;
        if (use_b) begin
            if (r.action == ACT_X2) num = num - stp * db;
            else                    num = num + stp * db;
        end
        neg = num[127];
        mag = neg ? -num : num;
        den = area << FRAC_BITS;
        // round half away from zero
        quo = (2 * mag + den) / (2 * den);
        if (quo > 128'(WORD_MAX) + neg) begin
            res.field_new = neg ? WORD_MIN : WORD_MAX;
            res.status    = STAT_SAT;
        end else begin
            res.field_new = neg ? -quo[WORD_BITS-1:0] : quo[WORD_BITS-1:0];
            res.status    = STAT_OK;
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return '0;
            4, 5: return $urandom();
            default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        endcase
    endfunction

    function automatic logic [31:0] pick_len();
        case ($urandom_range(0, 7))
            0: return 32'hffff_ffff;
            1: return '0;
            2: return $urandom();
            default: return $urandom_range(1 << 14, 3 << 16);
        endcase
    endfunction

    function automatic t_req random_face();
        t_req r;
        r.action    = $urandom_range(0, 15) == 0 ? ACT_NONE : 2'($urandom_range(0, 2));
        r.field_now = pick_word();
        r.field_old = pick_word();
        r.face_area = $urandom_range(0, 15) == 0 ? '0 : pick_len();
        r.len_a_lo  = pick_len();
        r.len_a_hi  = pick_len();
        r.emf_a_lo  = pick_word();
        r.emf_a_hi  = pick_word();
        r.len_b_lo  = pick_len();
        r.len_b_hi  = pick_len();
        r.emf_b_lo  = pick_word();
        r.emf_b_hi  = pick_word();
        return r;
    endfunction

    // sender: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_start && !o_busy) begin
                expected_fields.push_back(predict_face(i_req));
                faces_sent <= faces_sent + 1;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_start  <= 1'b0;
            end else if (pending_faces.size() > 0) begin
                i_req   <= pending_faces.pop_front();
                i_start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            fields_seen <= fields_seen + 1;
            if (expected_fields.size() == 0) begin
                $error("field result with no request outstanding");
                errors = errors + 1;
            end else begin
                want = expected_fields.pop_front();
                if (o_rsp.field_new !== want.field_new) begin
                    $error("field_new expected %h actual %h", want.field_new, o_rsp.field_new);
                    errors = errors + 1;
                end
                if (o_rsp.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_rsp.status);
                    errors = errors + 1;
                end
                if (want.status == STAT_SAT)  sat_seen  <= sat_seen + 1;
                if (want.status == STAT_AREA) area_seen <= area_seen + 1;
            end
        end
    end

    // register copy follows the write channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_cur_r <= GAIN_ONE;
            gain_old_r <= '0;
            step_r     <= '0;
            multi_r    <= 1'b1;
            three_r    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GAIN_CURRENT: gain_cur_r <= i_cfg_data;
                CFG_GAIN_OLD:     gain_old_r <= i_cfg_data;
                CFG_STEP_SCALE:   step_r     <= i_cfg_data;
                CFG_MULTI_DIM:    multi_r    <= i_cfg_data[0];
                CFG_THREE_DIM:    three_r    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_faces.size() > 0 || i_start || expected_fields.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_directed();
        t_req r;
        for (int a = 0; a < 4; a++) begin
            r = '0;
            r.action    = 2'(a);
            r.field_now = 32'h7fff_ffff;
            r.field_old = 32'h8000_0000;
            r.face_area = 32'h0001_0000;
            r.len_a_lo  = 32'hffff_ffff;
            r.len_a_hi  = 32'h0001_0000;
            r.emf_a_lo  = 32'h8000_0000;
            r.emf_a_hi  = 32'h7fff_ffff;
            r.len_b_lo  = 32'h0001_0000;
            r.len_b_hi  = 32'hffff_ffff;
            r.emf_b_lo  = 32'h7fff_ffff;
            r.emf_b_hi  = 32'h8000_0000;
            pending_faces.push_back(r);
            r.face_area = '0;
            pending_faces.push_back(r);
            r.field_now = 32'h8000_0000;
            r.field_old = 32'h7fff_ffff;
            r.face_area = 32'hffff_ffff;
            pending_faces.push_back(r);
            r.field_now = 32'hffff_8000;
            r.face_area = 32'h0000_0001;
            pending_faces.push_back(r);
            r = random_face();
            r.action = 2'(a);
            pending_faces.push_back(r);
        end
    endtask

    logic [WORD_BITS-1:0] set_gc[8] = '{GAIN_ONE, WORD_MAX, WORD_MIN, 32'h0000_8000,
                                        GAIN_ONE, 32'hffff_0000, 32'h0001_8000, 32'h0};
    logic [WORD_BITS-1:0] set_go[8] = '{32'h0, WORD_MIN, WORD_MAX, 32'h0000_8000,
                                        32'h0, 32'h0000_4000, 32'hffff_c000, 32'hffff_ffff};
    logic [WORD_BITS-1:0] set_st[8] = '{32'h0000_1000, WORD_MAX, WORD_MIN, 32'h0,
                                        32'hffff_f000, 32'h0000_0400, 32'h0002_0000, 32'h1};

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_GAIN_CURRENT;
        i_cfg_data  = '0;
        errors = 0; faces_sent = 0; fields_seen = 0;
        sat_seen = 0; area_seen = 0; idle_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset values first, with the directed faces
        add_directed();
        for (int k = 0; k < 80; k++) pending_faces.push_back(random_face());
        for (int p = 0; p < 8; p++) begin
            // sender holds off until every result is back before the registers change
            wait_drained();
            write_reg(CFG_GAIN_CURRENT, set_gc[p]);
            write_reg(CFG_GAIN_OLD, set_go[p]);
            write_reg(CFG_STEP_SCALE, set_st[p]);
            write_reg(CFG_MULTI_DIM, WORD_BITS'(p[0]));
            write_reg(CFG_THREE_DIM, WORD_BITS'(p[1]));
            for (int k = 0; k < 95; k++) pending_faces.push_back(random_face());
        end
        wait_drained();
        $display("%0d face requests, %0d results, %0d saturated, %0d zero area, 9 settings",
                 faces_sent, fields_seen, sat_seen, area_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
